[hdl/lpfs_pkg.sv]
// Shared types and constants for the length-prefixed frame splitter.
// No dependencies; every other file in hdl/ uses this package.
package lpfs_pkg;

   localparam int HEADER_BYTES = 7;
   localparam int HDR_IDX_W    = 3;
   localparam logic [HDR_IDX_W-1:0] HDR_LAST = HDR_IDX_W'(HEADER_BYTES - 1);

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAGIC_FIRST      = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_MAGIC_SECOND     = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_EXPECTED_VERSION = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_FRAME_SIZE   = CSR_IDX_W'(3);

   localparam logic [31:0] MAX_FRAME_RESET = 32'd65536;

   typedef enum logic [1:0] {
      ERR_NONE    = 2'd0,
      ERR_MAGIC   = 2'd1,
      ERR_VERSION = 2'd2,
      ERR_SIZE    = 2'd3
   } err_type;

   typedef enum logic [2:0] {
      ST_HEADER,
      ST_CHECK,
      ST_BURST,
      ST_PAYLOAD,
      ST_FAILED
   } state_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       frame_first;
      logic       frame_last;
      err_type    error_code;
   } rsp_type;

   typedef struct packed {
      err_type     code;
      logic [31:0] count;
   } check_type;

endpackage

[hdl/lpfs_hdr.sv]
// Header capture and check for the frame splitter.
// Depends on lpfs_pkg.
module lpfs_hdr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           wr_en,
   input  logic [7:0]                     wr_byte,
   input  logic [lpfs_pkg::HDR_IDX_W-1:0] rd_idx,
   input  logic [7:0]                     magic_first,
   input  logic [7:0]                     magic_second,
   input  logic [7:0]                     expected_version,
   input  logic [31:0]                    max_frame_size,
   output logic                           wr_last,
   output logic [7:0]                     rd_byte,
   output lpfs_pkg::check_type            check
);

   logic [7:0]                     store_ff [lpfs_pkg::HEADER_BYTES];
   logic [lpfs_pkg::HDR_IDX_W-1:0] count_ff;
   logic [lpfs_pkg::HDR_IDX_W-1:0] count_in;
   logic [32:0]                    total;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[count_ff] <= wr_byte;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (wr_en) begin
         count_in = (count_ff == lpfs_pkg::HDR_LAST) ? '0 : count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign wr_last = wr_en && (count_ff == lpfs_pkg::HDR_LAST);
   assign rd_byte = store_ff[rd_idx];

   // Magic first, then version, then size; report only the first miss.
   always_comb begin
      check.count = {store_ff[3], store_ff[4], store_ff[5], store_ff[6]};
      total       = {1'b0, check.count} + 33'(lpfs_pkg::HEADER_BYTES);
      if (store_ff[0] != magic_first || store_ff[1] != magic_second) begin
         check.code = lpfs_pkg::ERR_MAGIC;
      end else if (store_ff[2] != expected_version) begin
         check.code = lpfs_pkg::ERR_VERSION;
      end else if (total > {1'b0, max_frame_size}) begin
         check.code = lpfs_pkg::ERR_SIZE;
      end else begin
         check.code = lpfs_pkg::ERR_NONE;
      end
   end

endmodule

[hdl/lpfs_rsp.sv]
// Result register for the frame splitter's response channel.
// Depends on lpfs_pkg.
module lpfs_rsp (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  lpfs_pkg::rsp_type load_data,
   output logic              can_load,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output lpfs_pkg::rsp_type rsp_data
);

   logic              valid_ff;
   logic              valid_in;
   lpfs_pkg::rsp_type data_ff;

   assign can_load = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

[hdl/length_prefixed_frame_splitter.sv]
// Top level of the length-prefixed frame splitter: sequencer, payload counter, registers.
// Depends on lpfs_pkg, lpfs_hdr and lpfs_rsp.
//
//  channel | handshake              | payload
//  --------+------------------------+----------------------------------------------
//  req     | req_valid / req_ready  | req_in_byte
//  rsp     | rsp_valid / rsp_ready  | rsp_out_byte, rsp_frame_first,
//          |                        | rsp_frame_last, rsp_error_code
//  csr     | csr_valid / csr_ready  | csr_index, csr_wdata
//
// Payload bytes pass one request per cycle straight into the result register when free.
// A header is captured as 7 request bytes, checked in the check state, then replayed
// as 7 results while requests are held off; the result register paces that burst.
// Reset (synchronous) returns to header capture and restores register defaults.
// A stalled rsp side holds the result register and, in payload, the req side.
// After a failed check every request is taken and dropped until reset.
module length_prefixed_frame_splitter (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [7:0]                     req_in_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [7:0]                     rsp_out_byte,
   output logic                           rsp_frame_first,
   output logic                           rsp_frame_last,
   output logic [1:0]                     rsp_error_code,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [lpfs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                    csr_wdata
);

   lpfs_pkg::state_type            state_ff;
   lpfs_pkg::state_type            state_in;
   logic [lpfs_pkg::HDR_IDX_W-1:0] burst_idx_ff;
   logic [lpfs_pkg::HDR_IDX_W-1:0] burst_idx_in;
   logic [31:0]                    payload_left_ff;
   logic [31:0]                    payload_left_in;

   logic [7:0]  magic_first_ff;
   logic [7:0]  magic_second_ff;
   logic [7:0]  expected_version_ff;
   logic [31:0] max_frame_size_ff;

   logic                hdr_wr;
   logic                hdr_wr_last;
   logic [7:0]          hdr_rd_byte;
   lpfs_pkg::check_type check;

   logic              rsp_load;
   logic              rsp_can_load;
   lpfs_pkg::rsp_type rsp_load_data;
   lpfs_pkg::rsp_type rsp_data;

   logic payload_last;
   logic check_bad;

   assign payload_last = (payload_left_ff <= 32'd1);
   assign check_bad    = (check.code != lpfs_pkg::ERR_NONE);

   // Configuration: always ready, out-of-range index is ignored.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_first_ff      <= 8'd0;
         magic_second_ff     <= 8'd0;
         expected_version_ff <= 8'd0;
         max_frame_size_ff   <= lpfs_pkg::MAX_FRAME_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            lpfs_pkg::CSR_MAGIC_FIRST:      magic_first_ff      <= csr_wdata[7:0];
            lpfs_pkg::CSR_MAGIC_SECOND:     magic_second_ff     <= csr_wdata[7:0];
            lpfs_pkg::CSR_EXPECTED_VERSION: expected_version_ff <= csr_wdata[7:0];
            lpfs_pkg::CSR_MAX_FRAME_SIZE:   max_frame_size_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   lpfs_hdr u_hdr (
      .clock            (clock),
      .reset            (reset),
      .wr_en            (hdr_wr),
      .wr_byte          (req_in_byte),
      .rd_idx           (burst_idx_ff),
      .magic_first      (magic_first_ff),
      .magic_second     (magic_second_ff),
      .expected_version (expected_version_ff),
      .max_frame_size   (max_frame_size_ff),
      .wr_last          (hdr_wr_last),
      .rd_byte          (hdr_rd_byte),
      .check            (check)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lpfs_pkg::ST_HEADER: begin
            if (hdr_wr_last) begin
               state_in = lpfs_pkg::ST_CHECK;
            end
         end
         lpfs_pkg::ST_CHECK: begin
            if (!check_bad) begin
               state_in = lpfs_pkg::ST_BURST;
            end else if (rsp_can_load) begin
               state_in = lpfs_pkg::ST_FAILED;
            end
         end
         lpfs_pkg::ST_BURST: begin
            if (rsp_can_load && burst_idx_ff == lpfs_pkg::HDR_LAST) begin
               state_in = (check.count == 32'd0) ? lpfs_pkg::ST_HEADER
                                                 : lpfs_pkg::ST_PAYLOAD;
            end
         end
         lpfs_pkg::ST_PAYLOAD: begin
            if (rsp_load && payload_last) begin
               state_in = lpfs_pkg::ST_HEADER;
            end
         end
         lpfs_pkg::ST_FAILED: begin
            state_in = lpfs_pkg::ST_FAILED;
         end
         default: begin
            state_in = lpfs_pkg::ST_HEADER;
         end
      endcase
   end

   // Outputs and counter updates.
   always_comb begin
      req_ready                 = 1'b0;
      hdr_wr                    = 1'b0;
      rsp_load                  = 1'b0;
      rsp_load_data.out_byte    = 8'd0;
      rsp_load_data.frame_first = 1'b0;
      rsp_load_data.frame_last  = 1'b0;
      rsp_load_data.error_code  = lpfs_pkg::ERR_NONE;
      burst_idx_in              = burst_idx_ff;
      payload_left_in           = payload_left_ff;
      case (state_ff)
         lpfs_pkg::ST_HEADER: begin
            req_ready = 1'b1;
            hdr_wr    = req_valid;
         end
         lpfs_pkg::ST_CHECK: begin
            // Error result carries zero byte and no marks.
            rsp_load                 = rsp_can_load && check_bad;
            rsp_load_data.error_code = check.code;
            burst_idx_in             = '0;
            payload_left_in          = check.count;
         end
         lpfs_pkg::ST_BURST: begin
            rsp_load                  = rsp_can_load;
            rsp_load_data.out_byte    = hdr_rd_byte;
            rsp_load_data.frame_first = (burst_idx_ff == '0);
            rsp_load_data.frame_last  = (burst_idx_ff == lpfs_pkg::HDR_LAST) &&
                                        (check.count == 32'd0);
            if (rsp_can_load && burst_idx_ff != lpfs_pkg::HDR_LAST) begin
               burst_idx_in = burst_idx_ff + 1'b1;
            end
         end
         lpfs_pkg::ST_PAYLOAD: begin
            // Pass each request straight through; advance the countdown.
            req_ready                = rsp_can_load;
            rsp_load                 = req_valid && rsp_can_load;
            rsp_load_data.out_byte   = req_in_byte;
            rsp_load_data.frame_last = payload_last;
            if (rsp_load) begin
               payload_left_in = payload_last ? 32'd0 : payload_left_ff - 32'd1;
            end
         end
         lpfs_pkg::ST_FAILED: begin
            // Drop everything until reset.
            req_ready = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= lpfs_pkg::ST_HEADER;
         burst_idx_ff    <= '0;
         payload_left_ff <= 32'd0;
      end else begin
         state_ff        <= state_in;
         burst_idx_ff    <= burst_idx_in;
         payload_left_ff <= payload_left_in;
      end
   end

   lpfs_rsp u_rsp (
      .clock     (clock),
      .reset     (reset),
      .load      (rsp_load),
      .load_data (rsp_load_data),
      .can_load  (rsp_can_load),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign rsp_out_byte    = rsp_data.out_byte;
   assign rsp_frame_first = rsp_data.frame_first;
   assign rsp_frame_last  = rsp_data.frame_last;
   assign rsp_error_code  = rsp_data.error_code;

`ifndef SYNTH
   a_no_req_during_burst: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lpfs_pkg::ST_CHECK || state_ff == lpfs_pkg::ST_BURST) |-> !req_ready)
      else $error("request taken while header check or burst in progress");

   a_error_locks: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && rsp_load_data.error_code != lpfs_pkg::ERR_NONE)
      |=> state_ff == lpfs_pkg::ST_FAILED)
      else $error("error result did not lock the splitter");

   a_failed_silent: assert property (@(posedge clock) disable iff (reset)
      state_ff == lpfs_pkg::ST_FAILED |-> !rsp_load)
      else $error("result produced after failure");

   a_payload_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == lpfs_pkg::ST_PAYLOAD |-> payload_left_ff != 32'd0)
      else $error("payload state with empty countdown");

   a_burst_first: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && rsp_load_data.frame_first) |-> state_ff == lpfs_pkg::ST_BURST)
      else $error("first mark outside header burst");
`endif

endmodule
